@@ src/fdr_pkg.sv @@
// Shared constants, types and state codes for the FDR step-up adjuster.
package fdr_pkg;

    localparam int MAX_TESTS  = 64;
    localparam int IDX_W      = $clog2(MAX_TESTS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int FRAC_BITS  = 16;
    localparam int P_W        = FRAC_BITS + 1;
    localparam int FDR_W      = 16;
    localparam int PROD_W     = P_W + CNT_W;
    localparam int DCNT_W     = $clog2(PROD_W + 1);
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [P_W-1:0]   FIXED_ONE = P_W'(1) << FRAC_BITS;
    localparam logic [FDR_W-1:0] FDR_RESET = FDR_W'(3277);

    // Register index of the configuration map
    localparam logic [APB_ADDR_W-3:0] REG_FDR_LEVEL = '0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_WALK_RD,
        S_WALK_MUL,
        S_WALK_GO,
        S_WALK_DIV,
        S_OUT_RD,
        S_OUT_LOAD,
        S_OUT_HOLD
    } t_state;

endpackage

@@ src/fdr_step_up_adjuster_core.sv @@
// Top level: set collection, ranked insertion, BH walk and result emission.
// Insertion (S_INS_RD, S_INS_CMP) shifts larger entries up one rank each.
// After the last item the walk visits each rank downward (S_WALK_RD, S_WALK_MUL,
// S_WALK_GO, then the divider: 24 quotient bits); each result is then read, loaded
// and held while i_stall is high. One item at a time; o_stall is high while busy.
// Reset (i_rst_n low, synchronous) clears the set count, flags and FSM, fdr_level to 3277.
module fdr_step_up_adjuster_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fdr_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [fdr_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [fdr_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [fdr_pkg::P_W-1:0]           i_p_value,
    input  logic                              i_last,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [fdr_pkg::IDX_W-1:0]         o_test_index,
    output logic [fdr_pkg::P_W-1:0]           o_adjusted_value,
    output logic                              o_is_rejected,
    output logic [fdr_pkg::CNT_W-1:0]         o_rejected_total,
    output logic                              o_overflowed,
    output logic                              o_final_result
);
    import fdr_pkg::*;

    logic [FDR_W-1:0] fdr_level;

    fdr_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_fdr_level (fdr_level)
    );

    // Memories: sorted p-values with arrival index, per-arrival result
    logic [P_W-1:0]   sp_mem  [MAX_TESTS];
    logic [IDX_W-1:0] rk_mem  [MAX_TESTS];
    logic [P_W-1:0]   adj_mem [MAX_TESTS];
    logic [IDX_W-1:0] pos_mem [MAX_TESTS];

    t_state r_state, n_state;

    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_ovf, n_ovf;
    logic [P_W-1:0]    r_p, n_p;
    logic              r_last, n_last;
    logic [CNT_W-1:0]  r_pos, n_pos;
    logic [CNT_W-1:0]  r_m, n_m;
    logic [CNT_W-1:0]  r_r, n_r;
    logic [CNT_W-1:0]  r_largest, n_largest;
    logic [PROD_W-1:0] r_min, n_min;
    logic [PROD_W-1:0] r_prod, n_prod;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]  r_k, n_k;

    logic [P_W-1:0]    r_sp_rd;
    logic [IDX_W-1:0]  r_rk_rd;
    logic [P_W-1:0]    r_adj_rd;
    logic [IDX_W-1:0]  r_pos_rd;

    logic              r_ovalid, n_ovalid;
    logic [IDX_W-1:0]  r_o_idx, n_o_idx;
    logic [P_W-1:0]    r_o_adj, n_o_adj;
    logic              r_o_rej, n_o_rej;
    logic [CNT_W-1:0]  r_o_tot, n_o_tot;
    logic              r_o_ovf, n_o_ovf;
    logic              r_o_fin, n_o_fin;

    logic              sr_we;
    logic [IDX_W-1:0]  sr_waddr;
    logic [P_W-1:0]    sr_wp;
    logic [IDX_W-1:0]  sr_wrk;
    logic [IDX_W-1:0]  sr_raddr;
    logic              ap_we;
    logic [IDX_W-1:0]  ap_waddr;
    logic [P_W-1:0]    ap_wadj;
    logic [IDX_W-1:0]  ap_wpos;

    logic              div_start;
    logic              div_done;
    logic [PROD_W-1:0] div_q;
    logic [PROD_W-1:0] lhs, rhs;
    logic [PROD_W-1:0] newmin;
    logic              in_acc;

    fdr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_r),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // Sorted store: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (sr_we) begin
            sp_mem[sr_waddr] <= sr_wp;
            rk_mem[sr_waddr] <= sr_wrk;
        end
        r_sp_rd <= sp_mem[sr_raddr];
        r_rk_rd <= rk_mem[sr_raddr];
    end

    // Per-arrival store: one write, one registered read at the output counter
    always_ff @(posedge i_clk) begin
        if (ap_we) begin
            adj_mem[ap_waddr] <= ap_wadj;
            pos_mem[ap_waddr] <= ap_wpos;
        end
        r_adj_rd <= adj_mem[r_k[IDX_W-1:0]];
        r_pos_rd <= pos_mem[r_k[IDX_W-1:0]];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovf    <= n_ovf;
            r_ovalid <= n_ovalid;
        end
    end

    // Working and payload registers
    always_ff @(posedge i_clk) begin
        r_p       <= n_p;
        r_last    <= n_last;
        r_pos     <= n_pos;
        r_m       <= n_m;
        r_r       <= n_r;
        r_largest <= n_largest;
        r_min     <= n_min;
        r_prod    <= n_prod;
        r_idx     <= n_idx;
        r_k       <= n_k;
        r_o_idx   <= n_o_idx;
        r_o_adj   <= n_o_adj;
        r_o_rej   <= n_o_rej;
        r_o_tot   <= n_o_tot;
        r_o_ovf   <= n_o_ovf;
        r_o_fin   <= n_o_fin;
    end

    assign in_acc = i_valid && !o_stall;
    assign lhs    = PROD_W'(r_sp_rd) * PROD_W'(r_m);
    assign rhs    = PROD_W'(fdr_level) * PROD_W'(r_r);
    assign newmin = (div_q < r_min) ? div_q : r_min;

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ovf     = r_ovf;
        n_p       = r_p;
        n_last    = r_last;
        n_pos     = r_pos;
        n_m       = r_m;
        n_r       = r_r;
        n_largest = r_largest;
        n_min     = r_min;
        n_prod    = r_prod;
        n_idx     = r_idx;
        n_k       = r_k;
        n_ovalid  = r_ovalid;
        n_o_idx   = r_o_idx;
        n_o_adj   = r_o_adj;
        n_o_rej   = r_o_rej;
        n_o_tot   = r_o_tot;
        n_o_ovf   = r_o_ovf;
        n_o_fin   = r_o_fin;
        sr_we     = 1'b0;
        sr_waddr  = r_pos[IDX_W-1:0];
        sr_wp     = r_p;
        sr_wrk    = r_count[IDX_W-1:0];
        sr_raddr  = r_pos[IDX_W-1:0] - 1'b1;
        ap_we     = 1'b0;
        ap_waddr  = r_idx;
        ap_wadj   = (newmin > PROD_W'(FIXED_ONE)) ? FIXED_ONE : newmin[P_W-1:0];
        ap_wpos   = r_r[IDX_W-1:0] - 1'b1;
        div_start = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_p    = (i_p_value > FIXED_ONE) ? FIXED_ONE : i_p_value;
                    n_last = i_last;
                    n_pos  = r_count;
                    if (r_count < CNT_W'(MAX_TESTS)) begin
                        n_state = S_INS_RD;
                    end else begin
                        n_ovf = 1'b1;
                        if (i_last) begin
                            n_m       = r_count;
                            n_r       = r_count;
                            n_min     = '1;
                            n_largest = '0;
                            n_state   = S_WALK_RD;
                        end
                    end
                end
            end
            S_INS_RD: begin
                if (r_pos == '0) begin
                    // Reached the bottom: place the new item here
                    sr_we   = 1'b1;
                    n_count = r_count + 1'b1;
                    if (r_last) begin
                        n_m       = r_count + 1'b1;
                        n_r       = r_count + 1'b1;
                        n_min     = '1;
                        n_largest = '0;
                        n_state   = S_WALK_RD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_state = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                sr_we = 1'b1;
                if (r_sp_rd > r_p) begin
                    // Shift the larger entry up one rank
                    sr_wp   = r_sp_rd;
                    sr_wrk  = r_rk_rd;
                    n_pos   = r_pos - 1'b1;
                    n_state = S_INS_RD;
                end else begin
                    n_count = r_count + 1'b1;
                    if (r_last) begin
                        n_m       = r_count + 1'b1;
                        n_r       = r_count + 1'b1;
                        n_min     = '1;
                        n_largest = '0;
                        n_state   = S_WALK_RD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_WALK_RD: begin
                sr_raddr = r_r[IDX_W-1:0] - 1'b1;
                n_state  = S_WALK_MUL;
            end
            S_WALK_MUL: begin
                n_prod = lhs;
                n_idx  = r_rk_rd;
                // Walking downward, the first passing rank is the largest
                if (r_largest == '0 && lhs <= rhs) begin
                    n_largest = r_r;
                end
                n_state = S_WALK_GO;
            end
            S_WALK_GO: begin
                div_start = 1'b1;
                n_state   = S_WALK_DIV;
            end
            S_WALK_DIV: begin
                if (div_done) begin
                    ap_we = 1'b1;
                    n_min = newmin;
                    if (r_r == CNT_W'(1)) begin
                        n_k     = '0;
                        n_state = S_OUT_RD;
                    end else begin
                        n_r     = r_r - 1'b1;
                        n_state = S_WALK_RD;
                    end
                end
            end
            S_OUT_RD: begin
                n_state = S_OUT_LOAD;
            end
            S_OUT_LOAD: begin
                n_ovalid = 1'b1;
                n_o_idx  = r_k[IDX_W-1:0];
                n_o_adj  = r_adj_rd;
                n_o_rej  = ({1'b0, r_pos_rd} < r_largest);
                n_o_tot  = r_largest;
                n_o_ovf  = r_ovf;
                n_o_fin  = (r_k + 1'b1 == r_m);
                n_state  = S_OUT_HOLD;
            end
            S_OUT_HOLD: begin
                if (!i_stall) begin
                    n_ovalid = 1'b0;
                    if (r_o_fin) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = S_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_stall          = (r_state != S_IDLE);
    assign o_valid          = r_ovalid;
    assign o_test_index     = r_o_idx;
    assign o_adjusted_value = r_o_adj;
    assign o_is_rejected    = r_o_rej;
    assign o_rejected_total = r_o_tot;
    assign o_overflowed     = r_o_ovf;
    assign o_final_result   = r_o_fin;

endmodule

@@ src/fdr_cfg.sv @@
// APB-style configuration register block holding the target FDR level.
module fdr_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fdr_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [fdr_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [fdr_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output logic [fdr_pkg::FDR_W-1:0]         o_fdr_level
);
    import fdr_pkg::*;

    logic [FDR_W-1:0] r_fdr;
    logic             hit;

    assign hit = (paddr[APB_ADDR_W-1:2] == REG_FDR_LEVEL);

    // Register write on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fdr <= FDR_RESET;
        end else if (psel && penable && pwrite && hit) begin
            r_fdr <= pwdata[FDR_W-1:0];
        end
    end

    assign prdata      = hit ? APB_DATA_W'(r_fdr) : '0;
    assign pready      = 1'b1;
    assign o_fdr_level = r_fdr;

endmodule

@@ src/fdr_div.sv @@
// Restoring divider, one quotient bit per cycle, shared by every rank.
module fdr_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [fdr_pkg::PROD_W-1:0]    i_dividend,
    input  logic [fdr_pkg::CNT_W-1:0]     i_divisor,
    output logic                          o_done,
    output logic [fdr_pkg::PROD_W-1:0]    o_quotient
);
    import fdr_pkg::*;

    logic [PROD_W-1:0] r_quo;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div;
    logic [DCNT_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [CNT_W:0]    rem_sh;
    logic              fits;

    assign rem_sh = {r_rem, r_quo[PROD_W-1]};
    assign fits   = (rem_sh >= {1'b0, r_div});

    // Control: busy flag, step counter, done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(PROD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift, trial subtract
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[PROD_W-2:0], fits};
            r_rem <= fits ? CNT_W'(rem_sh - {1'b0, r_div}) : rem_sh[CNT_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

@@ bench/tb_top.sv @@
// Self-checking testbench for the FDR step-up adjuster: Benjamini-Hochberg adjustment per set.
`timescale 1ns / 1ps

module tb_top;
    import fdr_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0] test_index;
        logic [P_W-1:0]   adjusted_value;
        logic             is_rejected;
        logic [CNT_W-1:0] rejected_total;
        logic             overflowed;
        logic             final_result;
    } t_bh_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  i_valid;
    logic                  o_stall;
    logic [P_W-1:0]        i_p_value;
    logic                  i_last;
    logic                  o_valid;
    logic                  i_stall;
    logic [IDX_W-1:0]      o_test_index;
    logic [P_W-1:0]        o_adjusted_value;
    logic                  o_is_rejected;
    logic [CNT_W-1:0]      o_rejected_total;
    logic                  o_overflowed;
    logic                  o_final_result;

    fdr_step_up_adjuster_core dut (.*);

    // Predictor state
    logic [FDR_W-1:0] bh_fdr;
    logic [P_W-1:0]   set_pvals[$];
    logic             set_overflow;
    t_bh_result       expected_results[$];

    int  error_count;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  recv_hold;

    // Clock
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Compute the BH results for the closed set
    task automatic predict_set();
        int m;
        int order[$];
        logic [P_W-1:0]  adj[64];
        logic [63:0]     running, raw;
        int              largest;
        int              pos;
        t_bh_result      r;
        m = set_pvals.size();
        // stable ascending sort by insertion
        for (int i = 0; i < m; i++) begin
            pos = order.size();
            while (pos > 0 && set_pvals[order[pos-1]] > set_pvals[i]) pos--;
            order.insert(pos, i);
        end
        running = '1;
        for (int k = m; k > 0; k--) begin
            raw = (64'(set_pvals[order[k-1]]) * m) / k;
            if (raw < running) running = raw;
            adj[order[k-1]] = (running > 64'(FIXED_ONE)) ? FIXED_ONE : P_W'(running);
        end
        largest = 0;
        for (int k = 1; k <= m; k++)
            if (64'(set_pvals[order[k-1]]) * m <= 64'(bh_fdr) * k) largest = k;
        for (int i = 0; i < m; i++) begin
            r.test_index     = IDX_W'(i);
            r.adjusted_value = adj[i];
            r.is_rejected    = 1'b0;
            for (int k = 0; k < largest; k++)
                if (order[k] == i) r.is_rejected = 1'b1;
            r.rejected_total = CNT_W'(largest);
            r.overflowed     = set_overflow;
            r.final_result   = (i == m - 1);
            expected_results.insert(expected_results.size(), r);
        end
        set_pvals.delete();
        set_overflow = 1'b0;
    endtask

    // Offer one item and wait for acceptance; valid stays up until the next idle or drain
    task automatic send_item(input logic [P_W-1:0] p, input logic last);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid   <= 1'b0;
            i_p_value <= P_W'($urandom);
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_p_value <= p;
        i_last    <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (set_pvals.size() < MAX_TESTS)
            set_pvals.insert(set_pvals.size(), p > FIXED_ONE ? FIXED_ONE : p);
        else set_overflow = 1'b1;
        if (last) predict_set();
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_fdr(input logic [FDR_W-1:0] v);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({REG_FDR_LEVEL, 2'b00});
        pwdata  <= APB_DATA_W'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        bh_fdr = v;
        @(posedge i_clk);
    endtask

    function automatic logic [P_W-1:0] rand_p();
        case ($urandom_range(5))
            0:       rand_p = P_W'($urandom);
            1:       rand_p = P_W'($urandom_range(400));
            2:       rand_p = FIXED_ONE - P_W'($urandom_range(3));
            default: rand_p = P_W'($urandom_range(65536));
        endcase
    endfunction

    task automatic send_set(input int n);
        for (int i = 0; i < n; i++) send_item(rand_p(), i == n - 1);
    endtask

    // Directed: field extremes, ties, saturation, single-item set
    task automatic test_directed();
        send_item(P_W'(0), 1'b0);
        send_item(FIXED_ONE, 1'b0);
        send_item(P_W'(131071), 1'b0);
        send_item(P_W'(65537), 1'b0);
        send_item(P_W'(1), 1'b0);
        send_item(P_W'(1), 1'b1);
        send_item(P_W'(100), 1'b1);
        send_item(P_W'(0), 1'b0);
        send_item(P_W'(0), 1'b0);
        send_item(P_W'(43690), 1'b0);
        send_item(P_W'(21845), 1'b1);
        drain();
    endtask

    // Capacity overflow, last item dropped but closing the set
    task automatic test_overflow();
        for (int i = 0; i < MAX_TESTS + 3; i++)
            send_item(P_W'($urandom_range(3000)), i == MAX_TESTS + 2);
        drain();
    endtask

    // Random sets under several rate settings
    task automatic test_random_sets(input int items);
        int n, sent;
        sent = 0;
        while (sent < items) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(MAX_TESTS, 20) : $urandom_range(12, 1);
            send_set(n);
            sent += n;
        end
        drain();
    endtask

    // Long receiver hold-off while items keep coming; then pause until drained
    task automatic test_backpressure();
        recv_hold = 1'b1;
        send_set(4);
        send_set(5);
        recv_hold = 1'b0;
        drain();
        send_set(3);
        drain();
    endtask

    // Receiver stall, long hold-off counted in cycles
    initial begin
        int hold_cnt;
        bit hold_armed;
        hold_cnt = 0;
        hold_armed = 1'b0;
        i_stall = 1'b1;
        forever begin
            @(posedge i_clk);
            if (recv_hold && !hold_armed) begin
                hold_cnt   = 2000;
                hold_armed = 1'b1;
            end else if (!recv_hold) begin
                hold_armed = 1'b0;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= (recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        t_bh_result exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t unexpected result index %0d", $time, o_test_index);
                error_count++;
            end else begin
                exp_r = expected_results.pop_front();
                if (o_test_index !== exp_r.test_index ||
                    o_adjusted_value !== exp_r.adjusted_value ||
                    o_is_rejected !== exp_r.is_rejected ||
                    o_rejected_total !== exp_r.rejected_total ||
                    o_overflowed !== exp_r.overflowed ||
                    o_final_result !== exp_r.final_result) begin
                    $display("%0t mismatch: expected idx %0d adj %0d rej %0b tot %0d ovf %0b fin %0b",
                             $time, exp_r.test_index, exp_r.adjusted_value, exp_r.is_rejected,
                             exp_r.rejected_total, exp_r.overflowed, exp_r.final_result);
                    $display("%0t          actual   idx %0d adj %0d rej %0b tot %0d ovf %0b fin %0b",
                             $time, o_test_index, o_adjusted_value, o_is_rejected,
                             o_rejected_total, o_overflowed, o_final_result);
                    error_count++;
                end
            end
        end
    end

    // Main sequence
    initial begin
        error_count = 0;
        recv_hold = 1'b0;
        send_idle_pct = 34;
        recv_idle_pct = 80;
        bh_fdr = FDR_RESET;
        set_overflow = 1'b0;
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        i_valid = 1'b0; i_p_value = '0; i_last = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        write_fdr(FDR_W'(1));
        test_directed();
        write_fdr(FDR_W'(65535));
        test_directed();
        test_overflow();
        write_fdr(FDR_W'(3277));
        test_random_sets(130);
        send_idle_pct = 80;
        recv_idle_pct = 34;
        write_fdr(FDR_W'($urandom_range(65535, 1)));
        test_random_sets(120);
        test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_fdr(FDR_W'(20000));
        test_random_sets(120);

        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Timeout
    initial begin
        #60ms;
        $display("FAIL");
        $finish;
    end

endmodule
